// ----- rtl/rrip_ship_stream_replacement_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RRIP replacement core
// Shared property wrappers; clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef RRIP_SHIP_STREAM_REPLACEMENT_CORE_DEFINES_SVH
`define RRIP_SHIP_STREAM_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define RSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants and control types of the RRIP replacement core.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // NUM_SETS and DUEL_PERIOD are powers of two
  localparam int NUM_SETS_DEF       = 2048;
  localparam int NUM_WAYS_DEF       = 16;
  localparam int SIGNATURE_BITS_DEF = 10;
  localparam int SELECTOR_BITS_DEF  = 10;
  localparam int DUEL_PERIOD_DEF    = 64;
  localparam int LEADERS_DEF        = 32;

  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int ADDR_W     = 64;
  localparam int HASH_A     = 13;
  localparam int HASH_B     = 23;
  localparam int BIP_W      = 6;

  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] RRPV_MID   = 2'd2;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] CTR_MAX    = 2'd3;
  localparam logic [1:0] REUSE_INIT = 2'd1;
  localparam logic [1:0] STREAM_INIT = 2'd0;

  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic cmd;
  } dp_status_t;

endpackage

// ----- rtl/rsc_ram.sv -----
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: clearing pass, accept, read-modify-write commit, output word.
// ----------------------------------------------------------------------------
module rsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rsc_pkg::dp_status_t status,
  output rsc_pkg::ctrl_cmd_t  cmd,
  output logic                clearing
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd.clear  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold the read data until the output word has room
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign clearing  = (state_r == ST_CLEAR);

endmodule

// ----- rtl/rsc_datapath.sv -----
// ----------------------------------------------------------------------------
// rsc_datapath
// RRPV row memory, signature counter memories, duel selector, stride tracker.
// ----------------------------------------------------------------------------
module rsc_datapath #(
  parameter int NUM_SETS           = rsc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS           = rsc_pkg::NUM_WAYS_DEF,
  parameter int SIGNATURE_BITS     = rsc_pkg::SIGNATURE_BITS_DEF,
  parameter int SELECTOR_BITS      = rsc_pkg::SELECTOR_BITS_DEF,
  parameter int DUEL_PERIOD        = rsc_pkg::DUEL_PERIOD_DEF,
  parameter int LEADERS_PER_POLICY = rsc_pkg::LEADERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rsc_pkg::ctrl_cmd_t                cmd,
  output rsc_pkg::dp_status_t               status,
  input  logic                              in_cmd,
  input  logic [rsc_pkg::SET_IN_W-1:0]      in_set_index,
  input  logic [rsc_pkg::WAY_IN_W-1:0]      in_way_index,
  input  logic [rsc_pkg::ADDR_W-1:0]        in_pc,
  input  logic [rsc_pkg::ADDR_W-1:0]        in_phys_addr,
  input  logic                              in_was_hit,
  output logic [rsc_pkg::WAY_IN_W-1:0]      out_victim_way,
  output logic                              out_is_victim_reply
);

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int SIG_N   = 2 ** SIGNATURE_BITS;
  localparam int CLR_N   = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int ROW_W   = 2 * NUM_WAYS;
  localparam int DP_W    = $clog2(DUEL_PERIOD);
  localparam int ADDR_W  = rsc_pkg::ADDR_W;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;

  logic [CLR_W-1:0]          clr_cnt_r;
  logic                      cmd_r;
  logic [SET_W-1:0]          set_r;
  logic [rsc_pkg::WAY_IN_W-1:0] way_r;
  logic [SIGNATURE_BITS-1:0] sig_r;
  logic                      bip_zero_r;
  logic [ADDR_W-1:0]         addr_r;
  logic                      hit_r;
  logic [ADDR_W-1:0]         prev_addr_r, prev_stride_r;
  logic [SELECTOR_BITS-1:0]  sel_r, sel_nxt;
  logic [rsc_pkg::WAY_IN_W-1:0] vict_r;
  logic                      is_vict_r;

  logic [ADDR_W-1:0]         hash;
  logic [SET_W-1:0]          set_in;
  logic [ROW_W-1:0]          row_rd, row_wr;
  logic [1:0]                reuse_rd, stream_rd, reuse_wr, stream_wr;
  logic                      row_we, reuse_we, stream_we;
  logic [SET_W-1:0]          row_waddr;
  logic [SIGNATURE_BITS-1:0] sig_waddr;

  assign hash   = in_pc ^ (in_pc >> rsc_pkg::HASH_A) ^ (in_pc >> rsc_pkg::HASH_B);
  assign set_in = SET_W'(in_set_index);

  // capture the word at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_cmd;
      set_r      <= set_in;
      way_r      <= in_way_index;
      sig_r      <= hash[SIGNATURE_BITS-1:0];
      bip_zero_r <= (hash[rsc_pkg::BIP_W-1:0] == '0);
      addr_r     <= in_phys_addr;
      hit_r      <= in_was_hit;
    end
  end

  // victim search on the aged row
  logic [NUM_WAYS-1:0][1:0] lanes, aged, upd;
  logic                     any_hi, top_lo;
  logic [1:0]               top, gap;
  logic [rsc_pkg::WAY_IN_W-1:0] vict_way;
  logic [NUM_WAYS-1:0]      hi_bits, both_bits, lo_bits;

  assign lanes = row_rd;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      hi_bits[w]   = lanes[w][1];
      lo_bits[w]   = lanes[w][0];
      both_bits[w] = lanes[w][1] & lanes[w][0];
    end
    any_hi = |hi_bits;
    top_lo = any_hi ? |both_bits : |lo_bits;
    top    = {any_hi, top_lo};
    gap    = rsc_pkg::RRPV_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = lanes[w] + gap;
    end
    vict_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[w] == rsc_pkg::RRPV_MAX) begin
        vict_way = rsc_pkg::WAY_IN_W'(w);
      end
    end
  end

  // miss path: stride check, selector, insertion
  logic [ADDR_W-1:0]        stride;
  logic                     match;
  logic [DP_W-1:0]          slot;
  logic                     lead_static, lead_bimodal, bimodal;
  logic [1:0]               ins, lane_val;

  assign stride       = addr_r - prev_addr_r;
  assign match        = (prev_addr_r != '0) && (stride == prev_stride_r);
  assign slot         = set_r[DP_W-1:0];
  assign lead_static  = 32'(slot) < 32'(LEADERS_PER_POLICY);
  assign lead_bimodal = !lead_static && (32'(slot) < 32'(2 * LEADERS_PER_POLICY));

  always_comb begin
    sel_nxt = sel_r;
    if (lead_static) begin
      if (sel_r != SEL_MAX) sel_nxt = sel_r + 1'b1;
    end else if (lead_bimodal) begin
      if (sel_r != '0) sel_nxt = sel_r - 1'b1;
    end
    stream_wr = stream_rd;
    if (match) begin
      if (stream_rd != rsc_pkg::CTR_MAX) stream_wr = stream_rd + 2'd1;
    end else if (stream_rd != 2'd0) begin
      stream_wr = stream_rd - 2'd1;
    end
    reuse_wr = (reuse_rd != rsc_pkg::CTR_MAX) ? reuse_rd + 2'd1 : reuse_rd;
    if (lead_static)       bimodal = 1'b0;
    else if (lead_bimodal) bimodal = 1'b1;
    else                   bimodal = sel_nxt > SEL_MID;
    if (stream_wr[1])     ins = rsc_pkg::RRPV_MAX;
    else if (reuse_rd[1]) ins = rsc_pkg::RRPV_NEAR;
    else if (!bimodal)    ins = rsc_pkg::RRPV_MID;
    else                  ins = bip_zero_r ? rsc_pkg::RRPV_NEAR : rsc_pkg::RRPV_MAX;
    lane_val = hit_r ? rsc_pkg::RRPV_NEAR : ins;
    upd = lanes;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (32'(way_r) == w) upd[w] = lane_val;
    end
  end

  // memory write side: clearing pass or commit
  always_comb begin
    row_we    = cmd.clear || cmd.commit;
    reuse_we  = cmd.clear || (cmd.commit && cmd_r == rsc_pkg::CMD_UPDATE && hit_r);
    stream_we = cmd.clear || (cmd.commit && cmd_r == rsc_pkg::CMD_UPDATE && !hit_r);
    row_waddr = cmd.clear ? clr_cnt_r[SET_W-1:0] : set_r;
    sig_waddr = cmd.clear ? clr_cnt_r[SIGNATURE_BITS-1:0] : sig_r;
    if (cmd.clear) begin
      row_wr = {NUM_WAYS{rsc_pkg::RRPV_MAX}};
    end else if (cmd_r == rsc_pkg::CMD_VICTIM) begin
      row_wr = aged;
    end else begin
      row_wr = upd;
    end
  end

  rsc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wr),
    .re    (cmd.load),
    .raddr (set_in),
    .rdata (row_rd)
  );

  rsc_ram #(.WIDTH(2), .DEPTH(SIG_N)) u_reuse (
    .clk   (clk),
    .we    (reuse_we),
    .waddr (sig_waddr),
    .wdata (cmd.clear ? rsc_pkg::REUSE_INIT : reuse_wr),
    .re    (cmd.load),
    .raddr (hash[SIGNATURE_BITS-1:0]),
    .rdata (reuse_rd)
  );

  rsc_ram #(.WIDTH(2), .DEPTH(SIG_N)) u_stream (
    .clk   (clk),
    .we    (stream_we),
    .waddr (sig_waddr),
    .wdata (cmd.clear ? rsc_pkg::STREAM_INIT : stream_wr),
    .re    (cmd.load),
    .raddr (hash[SIGNATURE_BITS-1:0]),
    .rdata (stream_rd)
  );

  logic miss_commit;
  assign miss_commit = cmd.commit && cmd_r == rsc_pkg::CMD_UPDATE && !hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      prev_addr_r   <= '0;
      prev_stride_r <= '0;
      sel_r         <= SEL_MID;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (miss_commit) begin
        prev_addr_r   <= addr_r;
        prev_stride_r <= stride;
        sel_r         <= sel_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      vict_r    <= (cmd_r == rsc_pkg::CMD_VICTIM) ? vict_way : '0;
      is_vict_r <= (cmd_r == rsc_pkg::CMD_VICTIM);
    end
  end

  assign status.clear_last   = (32'(clr_cnt_r) == CLR_N - 1);
  assign status.cmd          = cmd_r;
  assign out_victim_way      = vict_r;
  assign out_is_victim_reply = is_vict_r;

endmodule

// ----- rtl/rrip_ship_stream_replacement_core.sv -----
// ----------------------------------------------------------------------------
// rrip_ship_stream_replacement_core
// RRIP cache replacement with set dueling, reuse and stream signatures.
// ----------------------------------------------------------------------------
// Input channel (in_*): one word per access. cmd 0 asks for a victim way of
// set_index, cmd 1 reports a hit or miss fill of way_index.
// Output channel (out_*): one word per input word, in order. A victim reply
// carries the way; an update acknowledge carries way 0.
// Each word takes two steps: accept with the row and counter reads, then one
// read-modify-write of the RRPV row memory and the signature counter memories.
// The result is written into an output register by the second step and shows in
// the cycle after it; the next word is taken while the result waits, but never
// before the write step of the word ahead of it.
// If the receiver stalls with a result pending, the next word holds its write
// step until the output register frees.
// Reset starts a clearing pass over max(NUM_SETS, 2**SIGNATURE_BITS) addresses
// (2048 by default) that fills all lines with 3, reuse counters with 1 and
// stream counters with 0; in_stall stays high for its length.
// ----------------------------------------------------------------------------
`include "rrip_ship_stream_replacement_core_defines.svh"

module rrip_ship_stream_replacement_core #(
  parameter int NUM_SETS           = rsc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS           = rsc_pkg::NUM_WAYS_DEF,
  parameter int SIGNATURE_BITS     = rsc_pkg::SIGNATURE_BITS_DEF,
  parameter int SELECTOR_BITS      = rsc_pkg::SELECTOR_BITS_DEF,
  parameter int DUEL_PERIOD        = rsc_pkg::DUEL_PERIOD_DEF,
  parameter int LEADERS_PER_POLICY = rsc_pkg::LEADERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [rsc_pkg::SET_IN_W-1:0]   in_set_index,
  input  logic [rsc_pkg::WAY_IN_W-1:0]   in_way_index,
  input  logic [rsc_pkg::ADDR_W-1:0]     in_pc,
  input  logic [rsc_pkg::ADDR_W-1:0]     in_phys_addr,
  input  logic                           in_was_hit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rsc_pkg::WAY_IN_W-1:0]   out_victim_way,
  output logic                           out_is_victim_reply
);

  rsc_pkg::ctrl_cmd_t  cmd;
  rsc_pkg::dp_status_t status;
  logic                clearing;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .clearing  (clearing)
  );

  rsc_datapath #(
    .NUM_SETS           (NUM_SETS),
    .NUM_WAYS           (NUM_WAYS),
    .SIGNATURE_BITS     (SIGNATURE_BITS),
    .SELECTOR_BITS      (SELECTOR_BITS),
    .DUEL_PERIOD        (DUEL_PERIOD),
    .LEADERS_PER_POLICY (LEADERS_PER_POLICY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_cmd              (in_cmd),
    .in_set_index        (in_set_index),
    .in_way_index        (in_way_index),
    .in_pc               (in_pc),
    .in_phys_addr        (in_phys_addr),
    .in_was_hit          (in_was_hit),
    .out_victim_way      (out_victim_way),
    .out_is_victim_reply (out_is_victim_reply)
  );

  `RSC_ASSERT_NEXT(a_one_word, in_valid && !in_stall, in_stall, "second word taken in flight")
  `RSC_ASSERT_NOW(a_clear_quiet, clearing, !out_valid && in_stall, "activity during clear")
  `RSC_ASSERT_NOW(a_ack_way, out_valid && !out_is_victim_reply, out_victim_way == '0,
    "update ack with nonzero way")
  `RSC_ASSERT_NEXT(a_commit_kind, cmd.commit, out_valid && out_is_victim_reply == !status.cmd,
    "result kind mismatch")

endmodule
